### rtl/checksummed_ring_counter_store_defines.svh
// assertion macros shared by the ring counter store
`ifndef CHECKSUMMED_RING_COUNTER_STORE_DEFINES_SVH
`define CHECKSUMMED_RING_COUNTER_STORE_DEFINES_SVH

// condition that holds at every edge out of reset
`define CRCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define CRCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/crcs_pkg.sv
`timescale 1ns / 1ps
package crcs_pkg;

  localparam int unsigned SlotCount  = 8;
  localparam logic [31:0] KmBound    = 32'd4294967;
  localparam logic [9:0]  KmScale    = 10'd1000;
  localparam logic [31:0] LimitReset = 32'd999999999;

  // action codes
  localparam logic [1:0] ActSave    = 2'd0;
  localparam logic [1:0] ActRecover = 2'd1;
  localparam logic [1:0] ActDiag    = 2'd2;
  localparam logic [1:0] ActLoad    = 2'd3;

  // microprogram step addresses
  localparam int unsigned PcW = 4;
  localparam logic [PcW-1:0] StepDispatch = 4'd0;
  localparam logic [PcW-1:0] StepSave     = 4'd1;
  localparam logic [PcW-1:0] StepLoad     = 4'd2;
  localparam logic [PcW-1:0] StepScanInit = 4'd3;
  localparam logic [PcW-1:0] StepScan     = 4'd4;
  localparam logic [PcW-1:0] StepRecDone  = 4'd5;
  localparam logic [PcW-1:0] StepMul      = 4'd6;
  localparam logic [PcW-1:0] StepDiagChk  = 4'd7;
  localparam logic [PcW-1:0] StepDiagW1   = 4'd8;
  localparam logic [PcW-1:0] StepDiagW2   = 4'd9;
  localparam logic [PcW-1:0] StepFinish   = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SAVE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_REC_DONE,
    OP_MUL,
    OP_DIAG_REJECT,
    OP_DIAG_W1,
    OP_DIAG_W2,
    OP_FINISH
  } crcs_op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_DISPATCH,
    COND_SCAN_MORE,
    COND_IF_RECOVER,
    COND_IF_REJECT,
    COND_WAIT_OUT
  } crcs_cond_e;

  typedef struct packed {
    crcs_op_e       op;
    crcs_cond_e     cond;
    logic [PcW-1:0] target;
  } crcs_ucode_t;

  typedef struct packed {
    crcs_op_e op;
    logic     accept;
  } crcs_ctrl_t;

  typedef struct packed {
    logic scan_last;
    logic is_recover;
    logic diag_ok;
    logic out_free;
  } crcs_stat_t;

  function automatic crcs_ucode_t ucode_rom(input logic [PcW-1:0] pc);
    crcs_ucode_t w;
    w = '{op: OP_NOP, cond: COND_DISPATCH, target: StepDispatch};
    unique case (pc)
      StepDispatch: w = '{op: OP_NOP,         cond: COND_DISPATCH,   target: StepDispatch};
      StepSave:     w = '{op: OP_SAVE,        cond: COND_JUMP,       target: StepFinish};
      StepLoad:     w = '{op: OP_LOAD,        cond: COND_JUMP,       target: StepFinish};
      StepScanInit: w = '{op: OP_SCAN_INIT,   cond: COND_NEXT,       target: StepDispatch};
      StepScan:     w = '{op: OP_SCAN_STEP,   cond: COND_SCAN_MORE,  target: StepScan};
      StepRecDone:  w = '{op: OP_REC_DONE,    cond: COND_IF_RECOVER, target: StepFinish};
      StepMul:      w = '{op: OP_MUL,         cond: COND_NEXT,       target: StepDispatch};
      StepDiagChk:  w = '{op: OP_DIAG_REJECT, cond: COND_IF_REJECT,  target: StepFinish};
      StepDiagW1:   w = '{op: OP_DIAG_W1,     cond: COND_NEXT,       target: StepDispatch};
      StepDiagW2:   w = '{op: OP_DIAG_W2,     cond: COND_NEXT,       target: StepDispatch};
      StepFinish:   w = '{op: OP_FINISH,      cond: COND_WAIT_OUT,   target: StepDispatch};
      default:      w = '{op: OP_NOP,         cond: COND_JUMP,       target: StepDispatch};
    endcase
    return w;
  endfunction

  function automatic logic [PcW-1:0] dispatch_rom(input logic [1:0] action);
    logic [PcW-1:0] t;
    t = StepDispatch;
    unique case (action)
      ActSave:    t = StepSave;
      ActRecover: t = StepScanInit;
      ActDiag:    t = StepScanInit;
      ActLoad:    t = StepLoad;
      default:    t = StepDispatch;
    endcase
    return t;
  endfunction

  // two's complement of the byte sum
  function automatic logic [7:0] check_of(input logic [31:0] v);
    logic [7:0] s;
    s = v[7:0] + v[15:8] + v[23:16] + v[31:24];
    return 8'(8'd0 - s);
  endfunction

endpackage

### rtl/crcs_in_if.sv
`timescale 1ns / 1ps
interface crcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] distance_in;
  logic [23:0] kilometres_in;
  logic [2:0]  slot_select;
  logic [7:0]  check_in;

  modport source (
    output valid, action, distance_in, kilometres_in, slot_select, check_in,
    input  ready
  );
  modport sink (
    input  valid, action, distance_in, kilometres_in, slot_select, check_in,
    output ready
  );
endinterface

### rtl/crcs_out_if.sv
`timescale 1ns / 1ps
interface crcs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance_out;
  logic [2:0]  slot_out;
  logic        found;
  logic        accepted;
  logic [7:0]  check_out;

  modport source (
    output valid, distance_out, slot_out, found, accepted, check_out,
    input  ready
  );
  modport sink (
    input  valid, distance_out, slot_out, found, accepted, check_out,
    output ready
  );
endinterface

### rtl/crcs_seq.sv
`timescale 1ns / 1ps
module crcs_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           action_i,
  input  crcs_pkg::crcs_stat_t stat_i,
  output logic                 in_ready_o,
  output crcs_pkg::crcs_ctrl_t ctrl_o
);

  logic [crcs_pkg::PcW-1:0] pc_q, pc_d, pc_inc;
  crcs_pkg::crcs_ucode_t    word;

  assign word   = crcs_pkg::ucode_rom(pc_q);
  assign pc_inc = pc_q + crcs_pkg::PcW'(1);

  always_comb begin
    pc_d = pc_q;
    unique case (word.cond)
      crcs_pkg::COND_NEXT:     pc_d = pc_inc;
      crcs_pkg::COND_JUMP:     pc_d = word.target;
      crcs_pkg::COND_DISPATCH: begin
        if (in_valid_i) begin
          pc_d = crcs_pkg::dispatch_rom(action_i);
        end
      end
      crcs_pkg::COND_SCAN_MORE:  pc_d = stat_i.scan_last ? pc_inc : word.target;
      crcs_pkg::COND_IF_RECOVER: pc_d = stat_i.is_recover ? word.target : pc_inc;
      crcs_pkg::COND_IF_REJECT:  pc_d = stat_i.diag_ok ? pc_inc : word.target;
      crcs_pkg::COND_WAIT_OUT:   pc_d = stat_i.out_free ? word.target : pc_q;
      default:                   pc_d = crcs_pkg::StepDispatch;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= crcs_pkg::StepDispatch;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_ready_o    = (word.cond == crcs_pkg::COND_DISPATCH);
  assign ctrl_o.op     = word.op;
  assign ctrl_o.accept = in_valid_i && in_ready_o;

endmodule

### rtl/crcs_dpath.sv
`timescale 1ns / 1ps
`include "checksummed_ring_counter_store_defines.svh"
module crcs_dpath #(
  parameter int unsigned SLOT_COUNT = crcs_pkg::SlotCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic [1:0]           action_i,
  input  logic [31:0]          distance_in_i,
  input  logic [23:0]          kilometres_in_i,
  input  logic [2:0]           slot_select_i,
  input  logic [7:0]           check_in_i,
  input  crcs_pkg::crcs_ctrl_t ctrl_i,
  output crcs_pkg::crcs_stat_t stat_o,
  crcs_out_if.source           out_o
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam logic [IW-1:0] LastIdx = IW'(SLOT_COUNT - 1);

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
    return (s == LastIdx) ? '0 : s + IW'(1);
  endfunction

  // slot memory with per-entry valid flags, unwritten entries read as zero
  logic [31:0]           slot_val_mem [SLOT_COUNT];
  logic [7:0]            slot_chk_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;
  logic [31:0]           rd_val_q;
  logic [7:0]            rd_chk_q;
  logic                  rd_vld_q;
  logic [IW-1:0]         rd_addr, wr_addr;
  logic                  wr_en;
  logic [31:0]           wr_val;
  logic [7:0]            wr_chk;

  logic [31:0]   limit_q;
  logic [1:0]    action_q;
  logic [31:0]   dist_q;
  logic [23:0]   km_q;
  logic [2:0]    sel_q;
  logic [7:0]    chk_q;

  logic [IW-1:0] ws_q, ws_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [31:0]   best_q, best_d;
  logic          found_q, found_d;
  logic [31:0]   nv_q, nv_d;
  logic          km_ok_q, km_ok_d;
  logic [33:0]   prod;

  logic [31:0]   res_dist_q, res_dist_d;
  logic          res_found_q, res_found_d;
  logic          res_acc_q, res_acc_d;
  logic [7:0]    res_chk_q, res_chk_d;

  logic          out_valid_q;
  logic [31:0]   out_dist_q;
  logic [2:0]    out_slot_q;
  logic          out_found_q, out_acc_q;
  logic [7:0]    out_chk_q;
  logic          out_free;

  logic [31:0]   cur_val, sel_ext, ws_ext;
  logic [7:0]    cur_chk;
  logic          hit, sel_ok;
  logic [IW-1:0] ws_next;

  assign cur_val = rd_vld_q ? rd_val_q : '0;
  assign cur_chk = rd_vld_q ? rd_chk_q : '0;
  assign hit     = (cur_chk == crcs_pkg::check_of(cur_val)) && (cur_val > best_q)
                   && (cur_val <= limit_q);
  assign sel_ext = 32'(sel_q);
  assign sel_ok  = sel_ext < 32'(SLOT_COUNT);
  assign ws_next = next_slot(ws_q);
  assign prod    = 34'(km_q) * 34'(crcs_pkg::KmScale);
  assign out_free = !out_valid_q || out_o.ready;
  assign rd_addr = (ctrl_i.op == crcs_pkg::OP_SCAN_INIT) ? '0 : next_slot(idx_q);

  always_comb begin
    ws_d        = ws_q;
    idx_d       = idx_q;
    best_d      = best_q;
    found_d     = found_q;
    nv_d        = nv_q;
    km_ok_d     = km_ok_q;
    res_dist_d  = res_dist_q;
    res_found_d = res_found_q;
    res_acc_d   = res_acc_q;
    res_chk_d   = res_chk_q;
    wr_en       = 1'b0;
    wr_addr     = ws_next;
    wr_val      = dist_q;
    wr_chk      = crcs_pkg::check_of(dist_q);
    unique case (ctrl_i.op)
      crcs_pkg::OP_SAVE: begin
        wr_en       = 1'b1;
        ws_d        = ws_next;
        res_dist_d  = dist_q;
        res_found_d = 1'b0;
        res_acc_d   = 1'b1;
        res_chk_d   = crcs_pkg::check_of(dist_q);
      end
      crcs_pkg::OP_LOAD: begin
        wr_en       = sel_ok;
        wr_addr     = IW'(sel_ext);
        wr_chk      = chk_q;
        res_dist_d  = dist_q;
        res_found_d = 1'b0;
        res_acc_d   = sel_ok;
        res_chk_d   = sel_ok ? chk_q : 8'd0;
      end
      crcs_pkg::OP_SCAN_INIT: begin
        idx_d   = '0;
        best_d  = '0;
        found_d = 1'b0;
      end
      crcs_pkg::OP_SCAN_STEP: begin
        idx_d = next_slot(idx_q);
        if (hit) begin
          best_d  = cur_val;
          ws_d    = idx_q;
          found_d = 1'b1;
        end
      end
      crcs_pkg::OP_REC_DONE: begin
        res_dist_d  = best_q;
        res_found_d = found_q;
        res_acc_d   = 1'b1;
        res_chk_d   = 8'd0;
      end
      crcs_pkg::OP_MUL: begin
        nv_d    = prod[31:0];
        km_ok_d = 32'(km_q) < crcs_pkg::KmBound;
      end
      crcs_pkg::OP_DIAG_REJECT: begin
        res_dist_d  = '0;
        res_found_d = 1'b0;
        res_acc_d   = 1'b0;
        res_chk_d   = 8'd0;
      end
      crcs_pkg::OP_DIAG_W1: begin
        wr_en       = 1'b1;
        wr_val      = nv_q;
        wr_chk      = crcs_pkg::check_of(nv_q);
        ws_d        = ws_next;
        res_dist_d  = nv_q;
        res_found_d = 1'b0;
        res_acc_d   = 1'b1;
        res_chk_d   = crcs_pkg::check_of(nv_q);
      end
      crcs_pkg::OP_DIAG_W2: begin
        wr_en  = 1'b1;
        wr_val = nv_q;
        wr_chk = crcs_pkg::check_of(nv_q);
        // pointer ends on the lower of the two written slots
        ws_d   = (ws_next < ws_q) ? ws_next : ws_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_val_mem[wr_addr] <= wr_val;
      slot_chk_mem[wr_addr] <= wr_chk;
    end
    rd_val_q <= slot_val_mem[rd_addr];
    rd_chk_q <= slot_chk_mem[rd_addr];
    rd_vld_q <= valid_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      limit_q     <= crcs_pkg::LimitReset;
      ws_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      ws_q <= ws_d;
      if (ctrl_i.op == crcs_pkg::OP_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      action_q <= action_i;
      dist_q   <= distance_in_i;
      km_q     <= kilometres_in_i;
      sel_q    <= slot_select_i;
      chk_q    <= check_in_i;
    end
    idx_q       <= idx_d;
    best_q      <= best_d;
    found_q     <= found_d;
    nv_q        <= nv_d;
    km_ok_q     <= km_ok_d;
    res_dist_q  <= res_dist_d;
    res_found_q <= res_found_d;
    res_acc_q   <= res_acc_d;
    res_chk_q   <= res_chk_d;
    if (ctrl_i.op == crcs_pkg::OP_FINISH && out_free) begin
      out_dist_q  <= res_dist_q;
      out_slot_q  <= ws_ext[2:0];
      out_found_q <= res_found_q;
      out_acc_q   <= res_acc_q;
      out_chk_q   <= res_chk_q;
    end
  end

  assign ws_ext = 32'(ws_q);

  assign stat_o.scan_last  = (idx_q == LastIdx);
  assign stat_o.is_recover = (action_q == crcs_pkg::ActRecover);
  assign stat_o.diag_ok    = km_ok_q && (best_q < nv_q) && (nv_q <= limit_q);
  assign stat_o.out_free   = out_free;

  assign out_o.valid        = out_valid_q;
  assign out_o.distance_out = out_dist_q;
  assign out_o.slot_out     = out_slot_q;
  assign out_o.found        = out_found_q;
  assign out_o.accepted     = out_acc_q;
  assign out_o.check_out    = out_chk_q;

  `CRCS_ASSERT_ALWAYS(a_ws_range, ws_q <= LastIdx, "write slot out of range")
  `CRCS_ASSERT_IMP(a_found_nonzero, out_valid_q && out_found_q, out_dist_q != 32'd0,
                   "found result with zero distance")
  `CRCS_ASSERT_IMP(a_found_acc, out_valid_q && out_found_q, out_acc_q,
                   "found result not marked accepted")
  `CRCS_ASSERT_IMP(a_reject_chk, out_valid_q && !out_acc_q, out_chk_q == 8'd0,
                   "rejected beat carries a check byte")

endmodule

### rtl/checksummed_ring_counter_store.sv
`timescale 1ns / 1ps
// Ring of SLOT_COUNT checksummed distance slots with save, recover, diagnostic set
// and raw load actions, one result beat per input beat. A recover and a diagnostic set
// run the recovery scan, which reads one slot from the slot memory per cycle under
// the microprogram, so they take longer than a save or load. A result waits in the
// output register while the next beat is taken.
module checksummed_ring_counter_store #(
  parameter int unsigned SLOT_COUNT = crcs_pkg::SlotCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  crcs_in_if.sink     in_i,
  crcs_out_if.source  out_o
);

  crcs_pkg::crcs_ctrl_t ctrl;
  crcs_pkg::crcs_stat_t stat;
  logic                 in_ready;

  assign in_i.ready = in_ready;

  crcs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .action_i   (in_i.action),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .ctrl_o     (ctrl)
  );

  crcs_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (in_i.action),
    .distance_in_i   (in_i.distance_in),
    .kilometres_in_i (in_i.kilometres_in),
    .slot_select_i   (in_i.slot_select),
    .check_in_i      (in_i.check_in),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .out_o           (out_o)
  );

endmodule
